### design/esf_pkg.sv
// Shared types, signature tables and match helpers for the exec signature filter.
`default_nettype none

package esf_pkg;

  // Window geometry and signature set.
  localparam int WINDOW_DEPTH = 11;
  localparam int SIG_COUNT    = 7;
  localparam int SIG_MAXLEN   = 12;

  // Verdict cause codes.
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_NAME = 2'd1;
  localparam logic [1:0] CAUSE_SIG  = 2'd2;

  // Signature lengths in bytes.
  localparam int SIG_LEN [SIG_COUNT] = '{9, 9, 7, 5, 7, 11, 12};

  // Signature text, right justified: the last character sits in bits [7:0],
  // so the character d places before the end sits in bits [8*d +: 8].
  localparam logic [SIG_MAXLEN*8-1:0] SIG_TEXT [SIG_COUNT] = '{
    "/dev/tcp/",
    "/dev/udp/",
    "bash -i",
    "nc -e",
    "ncat -e",
    "socat exec:",
    "mkfifo /tmp/"
  };

  // Control that every window cell sees in the same cycle.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // True when byte b fits signature sig at back places before its end,
  // or when the signature is no longer than that distance.
  function automatic logic sig_char_ok(input int sig, input int back,
                                       input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (back < SIG_LEN[sig]) begin
      ok = (SIG_TEXT[sig][8*back +: 8] == b);
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

### design/esf_if.sv
// Handshake channels for request bytes and verdict items.
`default_nettype none

interface esf_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       last_byte;
  logic       name_listed;

  modport source(output valid, cmd_byte, last_byte, name_listed, input ready);
  modport sink(input valid, cmd_byte, last_byte, name_listed, output ready);
endinterface

interface esf_verdict_if;
  logic        valid;
  logic        ready;
  logic        deny;
  logic [1:0]  cause;
  logic [31:0] blocked_total;
  logic [31:0] passed_total;
  logic [31:0] signature_total;
  logic [31:0] listed_total;

  modport source(output valid, deny, cause, blocked_total, passed_total,
                 signature_total, listed_total, input ready);
  modport sink(input valid, deny, cause, blocked_total, passed_total,
               signature_total, listed_total, output ready);
endinterface

`default_nettype wire

### design/esf_cell.sv
// One window cell: holds one past byte, passes it on, and checks it against every signature.
`default_nettype none

module esf_cell
  import esf_pkg::*;
#(
  parameter int DIST = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cell_ctl_t            ctl,
  input  wire logic [7:0]           byte_in,
  output logic      [7:0]           byte_out,
  output logic      [SIG_COUNT-1:0] hit
);

  logic [7:0] held;

  // Shift the window by one place, or empty it at a request boundary.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held <= '0;
    end else if (ctl.shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;

  // Compare the held byte with each signature's character at this distance.
  always_comb begin
    for (int s = 0; s < SIG_COUNT; s++) begin
      hit[s] = sig_char_ok(s, DIST, held);
    end
  end

endmodule

`default_nettype wire

### design/esf_sat_count.sv
// Saturating event counter.
`default_nettype none

module esf_sat_count #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             inc,
  output logic      [WIDTH-1:0] count
);

  // Count up on each event and stick at the all-ones value.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (inc && (count != '1)) begin
      count <= count + WIDTH'(1);
    end
  end

endmodule

`default_nettype wire

### design/exec_signature_filter.sv
// Top level of the exec signature filter: byte window, match logic, verdict and counters.
//
// The block takes one command line byte per item and accepts one item every clock
// cycle, back to back. The bytes move through a row of eleven window cells; each
// cell compares its byte against all seven reverse-shell signatures, so a signature
// ending at the current byte is known in the cycle the byte arrives. Only bytes at
// positions below LINE_BYTES are scanned, and a match counts only if it starts below
// START_LIMIT. On the item that carries last_byte, the verdict is registered and
// offered on the next cycle; while a verdict waits and is not taken, no byte is
// accepted, and a verdict taken in a cycle lets the next byte in during that same
// cycle. The four counters saturate at COUNT_WIDTH bits and report their low 32 bits.
`default_nettype none

module exec_signature_filter
  import esf_pkg::*;
#(
  parameter int LINE_BYTES  = 256,
  parameter int START_LIMIT = 200,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  esf_req_if.sink     req,
  esf_verdict_if.source verdict
);

  localparam int POS_W = $clog2(LINE_BYTES + 1);
  localparam int CMP_W = $clog2(LINE_BYTES + START_LIMIT + SIG_MAXLEN + 1) + 1;

  logic                   take;
  logic                   take_last;
  logic                   scan;
  logic [POS_W-1:0]       pos;
  logic                   seen;
  logic                   out_valid;
  logic                   deny_q;
  logic [1:0]             cause_q;
  cell_ctl_t              ctl;
  logic [7:0]             chain [0:WINDOW_DEPTH];
  logic [SIG_COUNT-1:0]   cell_hit [1:WINDOW_DEPTH];
  logic [SIG_COUNT-1:0]   cur_ok;
  logic [SIG_COUNT-1:0]   pos_ok;
  logic [SIG_COUNT-1:0]   sig_hit;
  logic                   any_hit;
  logic                   sig_deny;
  logic [CMP_W-1:0]       pos_ext;
  logic [COUNT_WIDTH-1:0] blocked_count;
  logic [COUNT_WIDTH-1:0] passed_count;
  logic [COUNT_WIDTH-1:0] signature_count;
  logic [COUNT_WIDTH-1:0] listed_count;
  logic [COUNT_WIDTH+31:0] blocked_wide;
  logic [COUNT_WIDTH+31:0] passed_wide;
  logic [COUNT_WIDTH+31:0] signature_wide;
  logic [COUNT_WIDTH+31:0] listed_wide;

  // Handshake: a byte is taken unless a verdict is waiting and is not being taken.
  assign req.ready = !out_valid || verdict.ready;
  assign take      = req.valid && req.ready;
  assign take_last = take && req.last_byte;
  assign scan      = (pos < POS_W'(LINE_BYTES));

  // Window control shared by all cells.
  assign ctl.shift = take && scan;
  assign ctl.clear = take_last;

  // Row of window cells; cell k holds the byte k places back.
  assign chain[0] = req.cmd_byte;
  for (genvar k = 1; k <= WINDOW_DEPTH; k++) begin : g_cell
    esf_cell #(.DIST(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .byte_in  (chain[k-1]),
      .byte_out (chain[k]),
      .hit      (cell_hit[k])
    );
  end

  // Match of each signature ending at the current byte, with its start in range.
  assign pos_ext = CMP_W'(pos);
  always_comb begin
    for (int s = 0; s < SIG_COUNT; s++) begin
      cur_ok[s] = sig_char_ok(s, 0, req.cmd_byte);
      pos_ok[s] = (pos_ext >= CMP_W'(SIG_LEN[s] - 1)) &&
                  (pos_ext < CMP_W'(START_LIMIT + SIG_LEN[s] - 1));
      sig_hit[s] = scan && cur_ok[s] && pos_ok[s];
      for (int k = 1; k <= WINDOW_DEPTH; k++) begin
        sig_hit[s] = sig_hit[s] && cell_hit[k][s];
      end
    end
  end

  assign any_hit  = |sig_hit;
  assign sig_deny = !req.name_listed && (seen || any_hit);

  // Byte position and per-request match flag.
  always_ff @(posedge clk) begin
    if (rst || take_last) begin
      pos  <= '0;
      seen <= 1'b0;
    end else if (take) begin
      if (scan) begin
        pos <= pos + POS_W'(1);
      end
      if (any_hit) begin
        seen <= 1'b1;
      end
    end
  end

  // Verdict register; counters hold still until the next final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      deny_q  <= req.name_listed || sig_deny;
      cause_q <= req.name_listed ? CAUSE_NAME : (sig_deny ? CAUSE_SIG : CAUSE_NONE);
    end
  end

  // Saturating counters.
  esf_sat_count #(.WIDTH(COUNT_WIDTH)) u_blocked (
    .clk (clk), .rst (rst),
    .inc (take_last && (req.name_listed || sig_deny)),
    .count (blocked_count)
  );
  esf_sat_count #(.WIDTH(COUNT_WIDTH)) u_passed (
    .clk (clk), .rst (rst),
    .inc (take_last && !req.name_listed && !sig_deny),
    .count (passed_count)
  );
  esf_sat_count #(.WIDTH(COUNT_WIDTH)) u_signature (
    .clk (clk), .rst (rst),
    .inc (take_last && sig_deny),
    .count (signature_count)
  );
  esf_sat_count #(.WIDTH(COUNT_WIDTH)) u_listed (
    .clk (clk), .rst (rst),
    .inc (take_last && req.name_listed),
    .count (listed_count)
  );

  // Report the low 32 bits of each counter, zero extended when narrower.
  assign blocked_wide   = {32'd0, blocked_count};
  assign passed_wide    = {32'd0, passed_count};
  assign signature_wide = {32'd0, signature_count};
  assign listed_wide    = {32'd0, listed_count};

  assign verdict.valid           = out_valid;
  assign verdict.deny            = deny_q;
  assign verdict.cause           = cause_q;
  assign verdict.blocked_total   = blocked_wide[31:0];
  assign verdict.passed_total    = passed_wide[31:0];
  assign verdict.signature_total = signature_wide[31:0];
  assign verdict.listed_total    = listed_wide[31:0];

  // A new verdict appears only after a final byte was taken.
  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(take_last))
    else $error("verdict raised without a final byte");

  // A final byte returns the window, position and match flag to their cleared state.
  a_request_clear: assert property (@(posedge clk) disable iff (rst)
    take_last |=> (chain[WINDOW_DEPTH] == '0) && (pos == '0) && !seen)
    else $error("request state not cleared after final byte");

  // Every signature or name denial is also counted as blocked.
  a_block_counts: assert property (@(posedge clk) disable iff (rst)
    (blocked_count >= signature_count) && (blocked_count >= listed_count))
    else $error("blocked count below a denial count");

  // Deny and cause agree on every offered verdict.
  a_cause_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (deny_q == (cause_q != CAUSE_NONE)))
    else $error("deny and cause disagree");

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for the exec signature filter: directed requests, then random traffic against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import esf_pkg::*;

  localparam int LINE_LEN    = 256;
  localparam int START_MAX   = 200;
  localparam int WIN_LEN     = 11;
  localparam int ITEM_TARGET  = 1150;
  localparam int RANDOM_REQS  = 20;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  // One verdict as the block reports it.
  typedef struct packed {
    logic        deny;
    logic [1:0]  cause;
    logic [31:0] blocked;
    logic [31:0] passed;
    logic [31:0] sigs;
    logic [31:0] listed;
  } verdict_t;

  // One directed request: pad bytes, then text, with an optional typed verdict.
  typedef struct {
    int         pad;
    logic [7:0] pad_val;
    string      text;
    bit         listed;
    bit         typed;
    verdict_t   want;
  } request_row_t;

  request_row_t directed_rows [21] = '{
    '{0,   8'h61, "ls -l",        1'b0, 1'b1, {1'b0, CAUSE_NONE, 32'd0, 32'd1, 32'd0, 32'd0}},
    '{0,   8'h61, "bash -i",      1'b0, 1'b1, {1'b1, CAUSE_SIG,  32'd1, 32'd1, 32'd1, 32'd0}},
    '{0,   8'h61, "bash -i",      1'b1, 1'b1, {1'b1, CAUSE_NAME, 32'd2, 32'd1, 32'd1, 32'd1}},
    '{1,   8'h00, "",             1'b0, 1'b1, {1'b0, CAUSE_NONE, 32'd2, 32'd2, 32'd1, 32'd1}},
    '{1,   8'hFF, "",             1'b1, 1'b1, {1'b1, CAUSE_NAME, 32'd3, 32'd2, 32'd1, 32'd2}},
    '{0,   8'h20, "/dev/tcp/",    1'b0, 1'b0, '0},
    '{3,   8'h78, "/dev/udp/x",   1'b0, 1'b0, '0},
    '{0,   8'h20, "nc -e",        1'b0, 1'b0, '0},
    '{0,   8'h20, "ncat -e host", 1'b0, 1'b0, '0},
    '{0,   8'h20, "socat exec:sh", 1'b0, 1'b0, '0},
    '{2,   8'h20, "mkfifo /tmp/f", 1'b0, 1'b0, '0},
    '{199, 8'h61, "nc -e",        1'b0, 1'b0, '0},
    '{200, 8'h61, "nc -e",        1'b0, 1'b0, '0},
    '{250, 8'h62, "bash -i",      1'b0, 1'b0, '0},
    '{5,   8'h00, "nc -e",        1'b0, 1'b0, '0},
    '{0,   8'h20, "bash -x",      1'b0, 1'b0, '0},
    '{0,   8'h20, "bash",         1'b0, 1'b0, '0},
    '{0,   8'h20, " -i",          1'b0, 1'b0, '0},
    '{0,   8'h20, "/dev/tcp/",    1'b1, 1'b0, '0},
    '{0,   8'h20, "nc -enc -e",   1'b0, 1'b0, '0},
    '{0,   8'h20, "BASH -I",      1'b0, 1'b0, '0}
  };

  string shell_sigs [7] = '{"/dev/tcp/", "/dev/udp/", "bash -i", "nc -e", "ncat -e",
                            "socat exec:", "mkfifo /tmp/"};
  string fill_set = "abcehikmnoprstux -/:.";

  logic clk;
  logic rst;

  esf_req_if     req ();
  esf_verdict_if verdict ();

  exec_signature_filter u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .verdict (verdict)
  );

  // Predictor state.
  logic [7:0]  recent [WIN_LEN];
  int          scan_pos;
  bit          sig_hit;
  logic [31:0] blocked_n, passed_n, sig_n, listed_n;

  verdict_t expected_verdicts [$];

  int errors = 0;
  int byte_total;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_now;
  bit hold_done = 1'b0;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  task automatic clear_request();
    foreach (recent[i]) recent[i] = 8'h00;
    scan_pos = 0;
    sig_hit  = 1'b0;
  endtask

  // True when signature s ends at the current byte and starts below the limit.
  function automatic bit sig_ends(input string s, input logic [7:0] cur);
    int n;
    bit ok;
    n  = s.len();
    ok = 1'b1;
    if (scan_pos + 1 < n || scan_pos - (n - 1) >= START_MAX || s[n-1] != cur) begin
      ok = 1'b0;
    end else begin
      for (int k = 1; k < n; k++) begin
        if (s[n-1-k] != recent[k-1]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Advance the predictor by one accepted byte; yields a verdict on the final byte.
  task automatic screen_byte(input logic [7:0] cur, input bit last, input bit listed,
                             output bit got, output verdict_t v);
    got = 1'b0;
    v   = '0;
    if (scan_pos < LINE_LEN) begin
      foreach (shell_sigs[s]) begin
        if (sig_ends(shell_sigs[s], cur)) sig_hit = 1'b1;
      end
      for (int i = WIN_LEN - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = cur;
      scan_pos++;
    end
    if (last) begin
      got = 1'b1;
      if (listed) begin
        v.deny    = 1'b1;
        v.cause   = CAUSE_NAME;
        listed_n  = sat_up(listed_n);
        blocked_n = sat_up(blocked_n);
      end else if (sig_hit) begin
        v.deny    = 1'b1;
        v.cause   = CAUSE_SIG;
        sig_n     = sat_up(sig_n);
        blocked_n = sat_up(blocked_n);
      end else begin
        v.deny    = 1'b0;
        v.cause   = CAUSE_NONE;
        passed_n  = sat_up(passed_n);
      end
      v.blocked = blocked_n;
      v.passed  = passed_n;
      v.sigs    = sig_n;
      v.listed  = listed_n;
      clear_request();
    end
  endtask

  // Offer one byte, with random gaps, and record what it should produce once taken.
  task automatic send_byte(input logic [7:0] b, input bit last, input bit listed,
                           input bit typed, input verdict_t want);
    bit got;
    verdict_t v;
    while (idle_on && $urandom_range(99) < 16) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.cmd_byte    <= b;
    req.last_byte   <= last;
    req.name_listed <= listed;
    do @(posedge clk); while (!req.ready);
    screen_byte(b, last, listed, got, v);
    if (got) expected_verdicts.push_back(typed ? want : v);
    byte_total++;
  endtask

  // The listed flag only matters on the final byte; elsewhere it is random noise.
  task automatic send_request(input logic [7:0] line [$], input bit listed,
                              input bit typed, input verdict_t want);
    int n;
    n = line.size();
    for (int i = 0; i < n; i++) begin
      send_byte(line[i], i == n - 1, (i == n - 1) ? listed : bit'($urandom_range(1)),
                typed, want);
    end
  endtask

  function automatic logic [7:0] fill_byte();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return fill_set[$urandom_range(fill_set.len() - 1)];
  endfunction

  // Mostly a signature with random padding, sometimes broken, sometimes near the start
  // limit; the rest is plain text or raw noise.
  task automatic make_request(output logic [7:0] line [$]);
    int kind;
    int pre;
    string sig;
    line.delete();
    kind = $urandom_range(99);
    if (kind < 70) begin
      pre = $urandom_range(12);
      if ($urandom_range(29) == 0) pre = $urandom_range(205, 185);
      repeat (pre) line.push_back(fill_byte());
      sig = shell_sigs[$urandom_range(6)];
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(1) == 1) sig.putc($urandom_range(sig.len() - 1), fill_byte());
        else sig = sig.substr(0, $urandom_range(sig.len() - 2));
      end
      for (int i = 0; i < sig.len(); i++) line.push_back(sig[i]);
      repeat ($urandom_range(6)) line.push_back(fill_byte());
    end else if (kind < 88) begin
      repeat ($urandom_range(20, 1)) line.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(15, 1)) line.push_back(fill_byte());
    end
  endtask

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", field, want, got);
      errors++;
    end
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      $error("verdict item arrived with none expected");
      errors++;
    end else begin
      want = expected_verdicts.pop_front();
      check_field("deny", want.deny, verdict.deny);
      check_field("cause", want.cause, verdict.cause);
      check_field("blocked_total", want.blocked, verdict.blocked_total);
      check_field("passed_total", want.passed, verdict.passed_total);
      check_field("signature_total", want.sigs, verdict.signature_total);
      check_field("listed_total", want.listed, verdict.listed_total);
    end
  endtask

  // Verdict side: check taken items, then choose ready, with one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      verdict.ready <= 1'b0;
    end else begin
      if (verdict.valid && verdict.ready) check_verdict();
      if (hold_left > 0) begin
        hold_left--;
        verdict.ready <= 1'b0;
      end else if (hold_now && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        verdict.ready <= 1'b0;
      end else begin
        verdict.ready <= !(idle_on && $urandom_range(99) < 16);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL exec_signature_filter");
      $finish;
    end
  end

  initial begin
    logic [7:0] line [$];
    int req_n;
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.cmd_byte    = 8'h00;
    req.last_byte   = 1'b0;
    req.name_listed = 1'b0;
    byte_total  = 0;
    hold_now    = 1'b0;
    idle_on     = 1'b1;
    clear_request();
    blocked_n = '0;
    passed_n  = '0;
    sig_n     = '0;
    listed_n  = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests from the table.
    foreach (directed_rows[r]) begin
      line.delete();
      repeat (directed_rows[r].pad) line.push_back(directed_rows[r].pad_val);
      for (int i = 0; i < directed_rows[r].text.len(); i++) begin
        line.push_back(directed_rows[r].text[i]);
      end
      send_request(line, directed_rows[r].listed, directed_rows[r].typed,
                   directed_rows[r].want);
    end

    // Sender pauses until every verdict so far has come back.
    req.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);

    // Random requests; the receiver starts with its long hold-off.
    hold_now = 1'b1;
    req_n    = 0;
    while (byte_total < ITEM_TARGET || req_n < RANDOM_REQS) begin
      idle_on = !(req_n >= 5 && req_n < 15);
      make_request(line);
      send_request(line, $urandom_range(3) == 0, 1'b0, '0);
      req_n++;
    end
    idle_on = 1'b1;
    req.valid <= 1'b0;

    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS exec_signature_filter");
    end else begin
      $display("FAIL exec_signature_filter");
    end
    $finish;
  end

endmodule

### sim.f
design/esf_pkg.sv
design/esf_if.sv
design/esf_cell.sv
design/esf_sat_count.sv
design/exec_signature_filter.sv
test/tb.sv
